// File: rtl/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/lsts_pkg.sv
// package for the lazy segment tree: types, codes and size constants
package lsts_pkg;
  localparam int MaxLenDefault = 1024;
  localparam int LenW = 11;
  localparam int IdxW = 10;
  localparam int LenReset = 1024;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpAssign = 2'd1;
  localparam logic [1:0] OpSum    = 2'd2;
  localparam logic [1:0] OpNone   = 2'd3;

  localparam logic [1:0] AddrActiveLength = 2'd0;

  typedef enum logic [4:0] {
    StClear, StIdle, StRead, StWait, StApplyGo, StApplyWait, StKidRd, StKidWait,
    StAsgGo, StAsgWait, StAddGo, StAddWait, StKidWr, StSplitPost, StSplitRight,
    StPop, StPullL, StPullR, StDone
  } state_t;
endpackage

// File: rtl/lsts_mult.sv
// iterative 64 x LenW multiplier, shift and add over one multiplier bit per cycle
module lsts_mult #(
  parameter int LenW = lsts_pkg::LenW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [63:0]     a,
  input  logic [LenW-1:0] b,
  output logic            done,
  output logic [63:0]     prod
);
  localparam int CntW = $clog2(LenW + 1);

  logic [63:0]     acc;
  logic [63:0]     mcand;
  logic [LenW-1:0] mplier;
  logic [CntW-1:0] cnt;
  logic            run;

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CntW'(LenW);
        acc <= '0;
        mcand <= a;
        mplier <= b;
      end else if (run) begin
        if (mplier[0]) acc <= acc + mcand;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule

// File: rtl/lazy_segment_tree_add_assign_sum.sv
// top level: lazy segment tree with range add, range assign and range sum
// Usage: active_length sits at APB byte address 0; a write clears the store and
// busy stays high until the clearing pass ends. A request is taken at the rising
// edge where start is high and busy is low; busy then stays high until the
// result. done pulses for one cycle with range_total and bad_range; the receiver
// cannot stall, and a new request can be taken in the cycle done is high.
// For a bad range or the unused opcode the request goes straight to done, with no walk.
// Otherwise an explicit stack walks the tree with one single-port node memory
// and one shift-add multiplier of PW = clog2(MAX_LEN)+1 bits. Per node: a node
// outside the range is read and popped, a covered node of a sum adds its total,
// a covered node of add or assign takes a product and is written back (a left
// child is read without a pop), and a split pushes the pull step and the right
// child, after pending marks are pushed down to each child through the multiplier.
// Reset and every active_length write run a clearing pass over all 4*MAX_LEN
// node words; reset sets active_length to 1024.
module lazy_segment_tree_add_assign_sum #(
  parameter int MAX_LEN = lsts_pkg::MaxLenDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic [lsts_pkg::IdxW-1:0] left_index,
  input  logic [lsts_pkg::IdxW-1:0] right_index,
  input  logic signed [31:0]        operand_value,
  output logic                      done,
  output logic signed [63:0]        range_total,
  output logic                      bad_range
);
  import lsts_pkg::*;
  `include "assert_macros.svh"

  localparam int Depth = 4 * MAX_LEN;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(MAX_LEN) + 1;   // position / length width
  localparam int SW    = $clog2(2 * $clog2(MAX_LEN) + 4);   // stack index bits
  localparam int SDep  = 1 << SW;

  typedef struct packed {
    logic [63:0] tot;
    logic [63:0] add;
    logic        asg;
    logic [63:0] aval;
  } node_t;

  typedef struct packed {
    logic [AW-1:0] v;
    logic [PW-1:0] tl;
    logic [PW-1:0] tr;
    logic          post;
  } frame_t;

  // configuration register
  logic [LenW-1:0] active_length;
  logic            cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == AddrActiveLength);
  assign prdata = (paddr == AddrActiveLength) ?
                  {{(32-LenW){1'b0}}, active_length} : 32'd0;

  // node memory, single port, registered read
  node_t         mem [Depth];
  logic [AW-1:0] maddr;
  logic          mwe;
  node_t         mwd;
  node_t         mrd;
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd <= mem[maddr];
  end

  // walk stack memory
  frame_t        stk [SDep];
  logic [SW-1:0] sp;
  logic          spush;
  frame_t        sdat;
  always_ff @(posedge clk) begin
    if (spush) stk[sp] <= sdat;
  end

  // request registers
  state_t        state, state_next;
  logic [1:0]    op;
  logic [PW-1:0] lq, rq;
  logic [63:0]   val;
  logic [63:0]   acc;
  logic [63:0]   ltot;
  logic          bad;
  logic [AW-1:0] ccnt;
  logic          cfg_pend;
  logic          side;          // 0 left child, 1 right child during push-down
  frame_t        cur;
  node_t         nd, kid;
  logic          mgo, mdone;
  logic [63:0]   ma, mp;
  logic [PW-1:0] mb;

  lsts_mult #(.LenW(PW)) u_mult (
    .clk(clk), .rst(rst), .go(mgo), .a(ma), .b(mb), .done(mdone), .prod(mp)
  );

  // segment helpers
  logic [PW-1:0] tm, lo_len, hi_len, seg_len, kid_len;
  logic [AW-1:0] lch, rch, kid_v;
  logic          fully, outside;
  assign tm      = PW'(({1'b0, cur.tl} + {1'b0, cur.tr}) >> 1);
  assign lo_len  = tm - cur.tl + 1'b1;
  assign hi_len  = cur.tr - tm;
  assign seg_len = cur.tr - cur.tl + 1'b1;
  assign lch     = {cur.v[AW-2:0], 1'b0};
  assign rch     = {cur.v[AW-2:0], 1'b1};
  assign kid_v   = side ? rch : lch;
  assign kid_len = side ? hi_len : lo_len;
  assign fully   = (lq <= cur.tl) && (cur.tr <= rq);
  assign outside = (cur.tl > rq) || (cur.tr < lq);

  // request decode
  logic [PW-1:0] eff_len;
  logic          bad_in;
  logic          accept;
  assign eff_len = (32'(active_length) > 32'(MAX_LEN)) ? PW'(MAX_LEN) :
                   PW'(active_length);
  assign bad_in  = (eff_len == '0) || (left_index > right_index) ||
                   (32'(right_index) >= 32'(eff_len));
  assign busy    = (state != StIdle) || cfg_pend || cfg_wr;
  assign accept  = start && !busy;

  // child mark: mult result applied to a node record
  function automatic node_t mark(node_t k, logic isasg, logic [63:0] v,
                                 logic [63:0] prod);
    node_t o;
    o = k;
    if (isasg) begin
      o.tot = prod; o.aval = v; o.asg = 1'b1; o.add = '0;
    end else begin
      o.tot = k.tot + prod; o.add = k.add + v;
    end
    return o;
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= StClear;
    else     state <= state_next;
  end

  // next state, memory port, multiplier and stack control
  always_comb begin
    state_next = state;
    mwe = 1'b0;
    maddr = cur.v;
    mwd = kid;
    mgo = 1'b0;
    ma = '0;
    mb = '0;
    spush = 1'b0;
    sdat = cur;
    unique case (state)
      StClear: begin
        mwe = 1'b1; maddr = ccnt; mwd = '0;
        if (!cfg_wr && ccnt == AW'(Depth - 1)) state_next = StIdle;
      end
      StIdle: begin
        if (cfg_wr || cfg_pend) state_next = StClear;
        else if (start) state_next = (bad_in || opcode == OpNone) ? StDone : StRead;
      end
      StRead: begin
        if (cur.post) begin
          maddr = lch;
          state_next = StPullL;
        end else if (outside) begin
          state_next = StPop;
        end else begin
          state_next = StWait;
        end
      end
      StWait: begin
        if (fully) state_next = (op == OpSum) ? StPop : StApplyGo;
        else if (mrd.asg || mrd.add != '0) state_next = StKidRd;
        else state_next = StSplitPost;
      end
      StApplyGo: begin
        mgo = 1'b1; ma = val; mb = seg_len;
        state_next = StApplyWait;
      end
      StApplyWait: begin
        if (mdone) begin
          mwe = 1'b1;
          mwd = mark(nd, op == OpAssign, val, mp);
          state_next = StPop;
        end
      end
      StKidRd: begin
        maddr = kid_v;
        state_next = StKidWait;
      end
      StKidWait: state_next = nd.asg ? StAsgGo : StAddGo;
      StAsgGo: begin
        mgo = 1'b1; ma = nd.aval; mb = kid_len;
        state_next = StAsgWait;
      end
      StAsgWait: if (mdone) state_next = (nd.add != '0) ? StAddGo : StKidWr;
      StAddGo: begin
        mgo = 1'b1; ma = nd.add; mb = kid_len;
        state_next = StAddWait;
      end
      StAddWait: if (mdone) state_next = StKidWr;
      StKidWr: begin
        mwe = 1'b1; maddr = kid_v; mwd = kid;
        state_next = side ? StSplitPost : StKidRd;
      end
      StSplitPost: begin
        spush = 1'b1;
        sdat = '{v: cur.v, tl: cur.tl, tr: cur.tr, post: 1'b1};
        state_next = StSplitRight;
      end
      StSplitRight: begin
        spush = 1'b1;
        sdat = '{v: rch, tl: tm + 1'b1, tr: cur.tr, post: 1'b0};
        state_next = StRead;
      end
      StPop: state_next = (sp == '0) ? StDone : StRead;
      StPullL: begin
        maddr = rch;
        state_next = StPullR;
      end
      StPullR: begin
        // children totals summed, parent marks already pushed down
        mwe = 1'b1;
        mwd = '0;
        mwd.tot = ltot + mrd.tot;
        state_next = StPop;
      end
      StDone: state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  // datapath and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= LenW'(LenReset);
      ccnt <= '0;
      sp <= '0;
      cfg_pend <= 1'b0;
      done <= 1'b0;
      range_total <= '0;
      bad_range <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) active_length <= pwdata[LenW-1:0];
      if (cfg_wr && state != StIdle && state != StClear) cfg_pend <= 1'b1;
      else if (state == StClear) cfg_pend <= 1'b0;
      ccnt <= (state == StClear && !cfg_wr) ? ccnt + 1'b1 : '0;
      unique case (state)
        StIdle: begin
          if (accept) begin
            op  <= opcode;
            lq  <= PW'(left_index);
            rq  <= PW'(right_index);
            val <= {{32{operand_value[31]}}, operand_value};
            acc <= '0;
            bad <= bad_in;
            cur <= '{v: AW'(1), tl: '0, tr: eff_len - 1'b1, post: 1'b0};
          end
        end
        StWait: begin
          nd <= mrd;
          side <= 1'b0;
          if (fully && op == OpSum) acc <= acc + mrd.tot;
        end
        StKidWait: kid <= mrd;
        StAsgWait: if (mdone) kid <= mark(kid, 1'b1, nd.aval, mp);
        StAddWait: if (mdone) kid <= mark(kid, 1'b0, nd.add, mp);
        StKidWr: side <= 1'b1;
        StSplitPost: sp <= sp + 1'b1;
        StSplitRight: begin
          sp <= sp + 1'b1;
          cur <= '{v: lch, tl: cur.tl, tr: tm, post: 1'b0};
        end
        StPop: begin
          if (sp != '0) begin
            cur <= stk[sp - 1'b1];
            sp <= sp - 1'b1;
          end
        end
        StPullL: ltot <= mrd.tot;
        StDone: begin
          done <= 1'b1;
          range_total <= acc;
          bad_range <= bad;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_NEXT(a_done_pulse, done, !done)
  `ASSERT_IMPL(a_done_idle, done, state == StIdle)
  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `ASSERT_IMPL(a_idle_stack_empty, state == StIdle, sp == '0)
endmodule
